// File: hdl/tcfd_pkg.sv
// Shared types, codes and constants of the tone command frame decoder.
package tcfd_pkg;

    localparam int NUM_CHANNELS = 8;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 7;
    localparam int KIND_W    = 2;
    localparam int CHAN_W    = 3;
    localparam int VALUE_W   = 14;
    localparam int HP_W      = 19;

    localparam int FIRST_CHANNEL_ACTION = 12;
    localparam int HALF_PERIOD_NUM      = 500000;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int DIV_STEPS = HP_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [CODE_W-1:0] ACT_REINIT = 7'd0;
    localparam logic [CODE_W-1:0] ACT_ENABLE = 7'd1;

    localparam logic [KIND_W-1:0] KIND_REINIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PLAY   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } cmd_t;

endpackage

// File: hdl/tcfd_front.sv
// Frame parser that assembles three-byte frames and classifies them into commands.
module tcfd_front
    import tcfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              cmd_push,
    output cmd_t              cmd
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_ACT  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [CODE_W-1:0] act_reg, act_next;
    logic [CODE_W-1:0] first_reg, first_next;

    logic               is_action;
    logic [CODE_W-1:0]  act_off;
    logic               is_channel;
    logic               is_known;
    logic [VALUE_W-1:0] value;

    assign is_action = rx_byte[BYTE_W-1];
    assign act_off   = act_reg - CODE_W'(FIRST_CHANNEL_ACTION);
    assign is_channel = (act_reg >= CODE_W'(FIRST_CHANNEL_ACTION))
                     && (act_off < CODE_W'(NUM_CHANNELS));
    assign is_known  = (act_reg == ACT_REINIT) || (act_reg == ACT_ENABLE) || is_channel;

    assign value = ({first_reg, 7'd0} - VALUE_W'(first_reg)) + VALUE_W'(rx_byte[CODE_W-1:0]);

    always_comb
    begin
        cmd.value   = value;
        cmd.channel = '0;
        if (act_reg == ACT_REINIT)
        begin
            cmd.kind = KIND_REINIT;
        end
        else if (act_reg == ACT_ENABLE)
        begin
            cmd.kind = KIND_ENABLE;
        end
        else
        begin
            cmd.channel = act_off[CHAN_W-1:0];
            cmd.kind    = (value == '0) ? KIND_STOP : KIND_PLAY;
        end
    end

    assign cmd_push = accept && (phase_reg == PH_DATA) && !is_action && is_known;

    always_comb
    begin
        phase_next = phase_reg;
        act_next   = act_reg;
        first_next = first_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_ACT:
                begin
                    if (is_action)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        first_next = rx_byte[CODE_W-1:0];
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    if (is_action)
                    begin
                        act_next   = rx_byte[CODE_W-1:0];
                        phase_next = PH_ACT;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            act_reg   <= '0;
            first_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            first_reg <= first_next;
        end
    end

endmodule

// File: hdl/tcfd_queue.sv
// Short command queue between the frame parser and the command executor.
module tcfd_queue
    import tcfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic nonempty,
    output cmd_t rd_cmd
);

    cmd_t              slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign full     = (count_reg == QCNT_W'(Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/tcfd_back.sv
// Command executor with a bit-serial half-period divider and the result register.
module tcfd_back
    import tcfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_take,
    output logic              empty,
    input  logic              pop,
    output logic [KIND_W-1:0] kind,
    output logic [CHAN_W-1:0] channel,
    output logic              enable_all,
    output logic [HP_W-1:0]   half_period
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic               state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_W-1:0] div_reg, div_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [HP_W-1:0]    qd_reg, qd_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic               en_reg, en_next;
    logic [HP_W-1:0]    hp_reg, hp_next;

    logic               slot_free;
    logic [VALUE_W:0]   rem_sh;
    logic               ge;

    assign slot_free = !out_valid_reg || pop;
    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid && slot_free;
    assign rem_sh    = {rem_reg, qd_reg[HP_W-1]};
    assign ge        = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        qd_next        = qd_reg;
        kind_next      = kind_reg;
        chan_next      = chan_reg;
        en_next        = en_reg;
        hp_next        = hp_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    kind_next = cmd.kind;
                    chan_next = cmd.channel;
                    en_next   = (cmd.kind == KIND_ENABLE) && (cmd.value != '0);
                    hp_next   = '0;
                    if (cmd.kind == KIND_PLAY)
                    begin
                        div_next   = cmd.value;
                        rem_next   = '0;
                        qd_next    = HP_W'(HALF_PERIOD_NUM);
                        cnt_next   = DCNT_W'(DIV_STEPS - 1);
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? VALUE_W'(rem_sh - {1'b0, div_reg}) : rem_sh[VALUE_W-1:0];
                qd_next  = {qd_reg[HP_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    hp_next        = {qd_reg[HP_W-2:0], ge};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        qd_reg   <= qd_next;
        kind_reg <= kind_next;
        chan_reg <= chan_next;
        en_reg   <= en_next;
        hp_reg   <= hp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign kind        = kind_reg;
    assign channel     = chan_reg;
    assign enable_all  = en_reg;
    assign half_period = hp_reg;

endmodule

// File: hdl/tone_command_frame_decoder_top.sv
// Top level of the tone command frame decoder: parser, command queue and executor.
// Bytes are taken one per cycle while the command queue has room.
// A reinit, enable or stop result passes from the command queue to the result register.
// A play result passes from the command queue through the 19-step divider to the result register.
// The executor takes no new command while a play command is in its divider.
// Reset returns the parser to hunting for an action byte and empties the command queue and result register.
module tone_command_frame_decoder_top
    import tcfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              push,
    output logic              full,
    output logic [KIND_W-1:0] kind,
    output logic [CHAN_W-1:0] channel,
    output logic              enable_all,
    output logic [HP_W-1:0]   half_period,
    output logic              empty,
    input  logic              pop
);

    logic accept;
    logic cmd_push;
    cmd_t front_cmd;
    logic q_nonempty;
    cmd_t q_cmd;
    logic cmd_take;

    assign accept = push && !full;

    tcfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    tcfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (cmd_take),
        .nonempty (q_nonempty),
        .rd_cmd   (q_cmd)
    );

    tcfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_nonempty),
        .cmd         (q_cmd),
        .cmd_take    (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .channel     (channel),
        .enable_all  (enable_all),
        .half_period (half_period)
    );

    a_play_has_period: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_PLAY) |-> (half_period != '0))
        else $error("play transaction carries a zero half period");

    a_period_only_play: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_PLAY) |-> (half_period == '0))
        else $error("non-play transaction carries a half period");

    a_enable_only_global: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_ENABLE) |-> !enable_all)
        else $error("enable flag set on a non-enable transaction");

    a_channel_zero_global: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == KIND_REINIT || kind == KIND_ENABLE)) |-> (channel == '0))
        else $error("global transaction carries a channel");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tone command frame decoder top level.
module tb;
    import tcfd_pkg::*;

    typedef enum logic [1:0] {HUNT, GOT_ACTION, GOT_FIRST} frame_phase_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic              enable_all;
        logic [HP_W-1:0]   half_period;
    } tone_event_t;

    typedef struct {
        logic [BYTE_W-1:0] b;
        bit                typed;
        bit                fires;
        tone_event_t       ev;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 925;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_ROWS       = 27;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic [BYTE_W-1:0] rx_byte = '0;
    logic              push = 1'b0;
    logic              full;
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] channel;
    logic              enable_all;
    logic [HP_W-1:0]   half_period;
    logic              empty;
    logic              pop = 1'b0;

    frame_phase_e      phase_q = HUNT;
    logic [CODE_W-1:0] action_q = '0;
    logic [CODE_W-1:0] first_q = '0;
    tone_event_t       expected_events[$];
    int                mismatches = 0;
    int                sent = 0;
    int                send_idle_pct = 37;
    int                recv_idle_pct = 63;
    bit                hold_req = 1'b0;

    tone_command_frame_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .channel     (channel),
        .enable_all  (enable_all),
        .half_period (half_period),
        .empty       (empty),
        .pop         (pop)
    );

    always #4 clk = ~clk;

    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output tone_event_t ev);
        logic [VALUE_W-1:0] value;
        bit                 fires;
        ev = '0;
        fires = 1'b0;
        case (phase_q)
            GOT_ACTION:
            begin
                if (b[7])
                begin
                    phase_q = HUNT;
                end
                else
                begin
                    first_q = b[6:0];
                    phase_q = GOT_FIRST;
                end
            end
            GOT_FIRST:
            begin
                phase_q = HUNT;
                if (!b[7])
                begin
                    value = VALUE_W'(int'(first_q) * 127 + int'(b[6:0]));
                    if (action_q == ACT_REINIT)
                    begin
                        fires = 1'b1;
                        ev.kind = KIND_REINIT;
                    end
                    else if (action_q == ACT_ENABLE)
                    begin
                        fires = 1'b1;
                        ev.kind = KIND_ENABLE;
                        ev.enable_all = (value != 0);
                    end
                    else if (int'(action_q) >= FIRST_CHANNEL_ACTION &&
                             int'(action_q) < FIRST_CHANNEL_ACTION + NUM_CHANNELS)
                    begin
                        fires = 1'b1;
                        ev.channel = CHAN_W'(int'(action_q) - FIRST_CHANNEL_ACTION);
                        if (value == 0)
                        begin
                            ev.kind = KIND_STOP;
                        end
                        else
                        begin
                            ev.kind = KIND_PLAY;
                            ev.half_period = HP_W'(HALF_PERIOD_NUM / int'(value));
                        end
                    end
                end
            end
            default:
            begin
                if (b[7])
                begin
                    action_q = b[6:0];
                    phase_q = GOT_ACTION;
                end
            end
        endcase
        return fires;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input bit typed_fires,
                             input tone_event_t typed_ev);
        tone_event_t ev;
        bit          fires;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        fires = decode_byte(b, ev);
        if (typed)
        begin
            fires = typed_fires;
            ev = typed_ev;
        end
        if (fires)
            expected_events.push_back(ev);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_random_chunk();
        logic [CODE_W-1:0] act;
        logic [CODE_W-1:0] first;
        int                r;
        r = $urandom_range(99);
        if (r < 72)
        begin
            case ($urandom_range(9))
                0: act = ACT_REINIT;
                1: act = ACT_ENABLE;
                8, 9: act = CODE_W'($urandom_range(127));
                default: act = CODE_W'(FIRST_CHANNEL_ACTION + $urandom_range(NUM_CHANNELS - 1));
            endcase
            first = ($urandom_range(3) == 0) ? '0 : CODE_W'($urandom_range(127));
            send_byte({1'b1, act}, 1'b0, 1'b0, '0);
            send_byte({1'b0, first}, 1'b0, 1'b0, '0);
            send_byte({1'b0, CODE_W'($urandom_range(127))}, 1'b0, 1'b0, '0);
        end
        else if (r < 86)
        begin
            send_byte(BYTE_W'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
        else
        begin
            send_byte({1'b1, CODE_W'($urandom_range(127))}, 1'b0, 1'b0, '0);
            if ($urandom_range(1) == 1)
                send_byte({1'b0, CODE_W'($urandom_range(127))}, 1'b0, 1'b0, '0);
            send_byte({1'b1, CODE_W'($urandom_range(127))}, 1'b0, 1'b0, '0);
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        tone_event_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected transaction, kind %0d channel %0d half_period %0d",
                         $time, kind, channel, half_period);
                mismatches++;
            end
            else
            begin
                want = expected_events.pop_front();
                check_field("kind", want.kind, kind);
                check_field("channel", want.channel, channel);
                check_field("enable_all", want.enable_all, enable_all);
                check_field("half_period", want.half_period, half_period);
            end
        end
    end

    initial
    begin
        stim_row_t rows[N_ROWS];
        rows = '{
            '{8'h80, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, {KIND_REINIT, 3'd0, 1'b0, 19'd0}},
            '{8'h81, 1'b1, 1'b0, '0},
            '{8'h7F, 1'b1, 1'b0, '0},
            '{8'h7F, 1'b1, 1'b1, {KIND_ENABLE, 3'd0, 1'b1, 19'd0}},
            '{8'h81, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, {KIND_ENABLE, 3'd0, 1'b0, 19'd0}},
            '{8'h8C, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, {KIND_STOP, 3'd0, 1'b0, 19'd0}},
            '{8'h93, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h01, 1'b1, 1'b1, {KIND_PLAY, 3'd7, 1'b0, 19'd500000}},
            '{8'h8F, 1'b1, 1'b0, '0},
            '{8'h7F, 1'b1, 1'b0, '0},
            '{8'h7F, 1'b1, 1'b1, {KIND_PLAY, 3'd3, 1'b0, 19'd30}},
            '{8'h91, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h2E, 1'b0, 1'b0, '0},
            '{8'h8D, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'h8E, 1'b1, 1'b0, '0},
            '{8'h10, 1'b1, 1'b0, '0},
            '{8'h81, 1'b1, 1'b0, '0}
        };
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i])
            send_byte(rows[i].b, rows[i].typed, rows[i].fires, rows[i].ev);
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 37 : (p == 1) ? 63 : 0;
            recv_idle_pct = (p == 0) ? 63 : (p == 1) ? 37 : 0;
            if (p == 2)
                hold_req = 1'b1;
            while (sent < N_ROWS + (p + 1) * RANDOM_ITEMS / 3)
                send_random_chunk();
        end
        push <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("%0t: timeout, %0d transactions still expected", $time, expected_events.size());
        $display("status: fail");
        $finish;
    end

endmodule
